@@ design/ulenc_pkg.sv @@
// ----------------------------------------------------------------------------
// ulenc_pkg
// Shared types, constants and the 6-bit character mapping of the uuencode
// line encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ulenc_pkg;

   localparam int LINE_BYTES_DEF = 45;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_FETCH3,
      ST_CH0,
      ST_CH1,
      ST_CH2,
      ST_CH3,
      ST_SUM,
      ST_NL
   } state_type;

   // Zero maps to backquote, everything else to value plus space.
   function automatic logic [7:0] enc6(input logic [5:0] v);
      logic [7:0] ch;
      if (v == 6'd0) begin
         ch = CHAR_BACKQUOTE;
      end else begin
         ch = {2'b00, v} + CHAR_SPACE;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ design/uuencode_line_encoder_core.sv @@
// ----------------------------------------------------------------------------
// uuencode_line_encoder_core
// Gathers raw bytes into a line buffer and emits each line uuencoded, with a
// length character, data characters, a checksum character and a newline.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one raw byte per transfer, req_is_final marks the last byte of a
//           stream. A byte that does not close a line leaves req_ready high.
//   rsp_* : one ASCII character per transfer. rsp_run_last is set on the
//           newline that ends a line, rsp_stream_done on the newline of the
//           line that held a final byte.
//   A line closes when LINE_BYTES bytes are held or a final byte arrives.
//   req_ready then drops until the newline has been loaded into the output
//   register. A line of n bytes is sent as a length character, then one
//   pass per three-byte group: four fetch states of buffer reads (one read
//   port, registered data) and four character states through the single
//   character mapper; then the checksum character and the newline.
//   When the receiver stalls, the output register holds its character and
//   the sequencer waits; no character is dropped.
//   Reset is synchronous, active high: the line is emptied, the sum cleared
//   and the output register emptied. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uuencode_line_encoder_core #(
   parameter int LINE_BYTES = ulenc_pkg::LINE_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_is_final,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_last,
   output logic            rsp_stream_done
);

   import ulenc_pkg::*;

   localparam int ADDR_W = $clog2(LINE_BYTES);
   localparam int FILL_W = $clog2(LINE_BYTES + 1);
   localparam int CNT_W  = $clog2(LINE_BYTES + 3);

   state_type state_ff, state_in;

   logic [7:0]        line_mem [LINE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [5:0]        sum_ff, sum_in;
   logic              final_ff, final_in;
   logic [CNT_W-1:0]  grp_ff, grp_in;
   logic [7:0]        b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;

   logic              req_fire;
   logic              slot_free;
   logic              emit;
   logic              line_close;
   logic [CNT_W-1:0]  rd_addr_wide;
   logic              rd_en;
   logic [CNT_W-1:0]  fill_wide;
   logic [CNT_W-1:0]  grp_next;
   logic [FILL_W-1:0] fill_plus;
   logic [5:0]        char_val;

   assign req_ready       = (state_ff == ST_IDLE);
   assign req_fire        = req_valid && req_ready;
   assign slot_free       = !out_valid_ff || rsp_ready;
   assign fill_wide       = CNT_W'(fill_ff);
   assign grp_next        = grp_ff + CNT_W'(3);
   assign fill_plus       = fill_ff + FILL_W'(1);
   assign line_close      = req_is_final || (fill_plus == FILL_W'(LINE_BYTES));

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_run_last    = out_last_ff;
   assign rsp_stream_done = out_done_ff;

   // Character emitting states load the output register when it frees up.
   always_comb begin
      unique case (state_ff)
         ST_LEN, ST_CH0, ST_CH1, ST_CH2, ST_CH3, ST_SUM, ST_NL: emit = slot_free;
         default:                                               emit = 1'b0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && line_close) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (emit) begin
               state_in = ST_FETCH0;
            end
         end
         ST_FETCH0: state_in = ST_FETCH1;
         ST_FETCH1: state_in = ST_FETCH2;
         ST_FETCH2: state_in = ST_FETCH3;
         ST_FETCH3: state_in = ST_CH0;
         ST_CH0: begin
            if (emit) begin
               state_in = ST_CH1;
            end
         end
         ST_CH1: begin
            if (emit) begin
               state_in = ST_CH2;
            end
         end
         ST_CH2: begin
            if (emit) begin
               state_in = ST_CH3;
            end
         end
         ST_CH3: begin
            if (emit) begin
               state_in = (grp_next < fill_wide) ? ST_FETCH0 : ST_SUM;
            end
         end
         ST_SUM: begin
            if (emit) begin
               state_in = ST_NL;
            end
         end
         ST_NL: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Buffer read address: group base plus byte offset within the group
   always_comb begin
      unique case (state_ff)
         ST_FETCH1: rd_addr_wide = grp_ff + CNT_W'(1);
         ST_FETCH2: rd_addr_wide = grp_ff + CNT_W'(2);
         default:   rd_addr_wide = grp_ff;
      endcase
      rd_en = ((state_ff == ST_FETCH0) || (state_ff == ST_FETCH1) ||
               (state_ff == ST_FETCH2)) && (rd_addr_wide < CNT_W'(LINE_BYTES));
   end

   // Character source for the shared mapper
   always_comb begin
      unique case (state_ff)
         ST_LEN:  char_val = 6'(fill_ff);
         ST_CH0:  char_val = b0_ff[7:2];
         ST_CH1:  char_val = {b0_ff[1:0], b1_ff[7:4]};
         ST_CH2:  char_val = {b1_ff[3:0], b2_ff[7:6]};
         ST_CH3:  char_val = b2_ff[5:0];
         default: char_val = sum_ff;
      endcase
   end

   // Datapath and output register next values
   always_comb begin
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      final_in     = final_ff;
      grp_in       = grp_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (req_fire) begin
         fill_in  = fill_plus;
         sum_in   = sum_ff + req_data_byte[5:0];
         final_in = req_is_final;
         grp_in   = '0;
      end

      // Capture group bytes; missing bytes of the last group read as zero.
      if (state_ff == ST_FETCH1) begin
         b0_in = rd_data_ff;
      end
      if (state_ff == ST_FETCH2) begin
         b1_in = ((grp_ff + CNT_W'(1)) < fill_wide) ? rd_data_ff : 8'h00;
      end
      if (state_ff == ST_FETCH3) begin
         b2_in = ((grp_ff + CNT_W'(2)) < fill_wide) ? rd_data_ff : 8'h00;
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = (state_ff == ST_NL) ? CHAR_NEWLINE : enc6(char_val);
         out_last_in  = (state_ff == ST_NL);
         out_done_in  = (state_ff == ST_NL) && final_ff;
         if (state_ff == ST_CH3) begin
            grp_in = grp_next;
         end
         if (state_ff == ST_NL) begin
            fill_in = '0;
            sum_in  = '0;
         end
      end
   end

   // Line buffer: write on input transfer, registered read during output
   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_mem[fill_ff[ADDR_W-1:0]] <= req_data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr_wide[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff    <= final_in;
      grp_ff      <= grp_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   // An idle block never holds a full line.
   a_idle_not_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> fill_ff < FILL_W'(LINE_BYTES))
      else $error("line buffer full while idle");

   // A final byte always starts line output.
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_final |=> state_ff == ST_LEN)
      else $error("final byte did not close the line");

   // Line end markers only ride on a newline.
   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_out_char == CHAR_NEWLINE)
      else $error("line end flag on a non-newline character");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("stream end flag without line end");

   // Line counters are cleared once the newline is loaded.
   a_clear_after_line: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NL && slot_free |=> fill_ff == '0 && sum_ff == '0)
      else $error("line state not cleared after newline");

endmodule

`default_nettype wire
